@@ rtl/core/gpioirq_pkg.sv @@
// ----------------------------------------------------------------------------
// GPIO port package
// Shared widths, register indexes, request decode and lane/result types.
// ----------------------------------------------------------------------------
package gpioirq_pkg;

    localparam int PIN_COUNT  = 32;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

    localparam logic [INDEX_W-1:0] IDX_PAIR_END = 7'd14;
    localparam logic [INDEX_W-1:0] IDX_STATUS   = 7'd20;
    localparam logic [INDEX_W-1:0] IDX_RAW      = 7'd22;
    localparam logic [INDEX_W-1:0] IDX_EOI_L    = 7'd24;
    localparam logic [INDEX_W-1:0] IDX_EOI_H    = 7'd25;
    localparam logic [INDEX_W-1:0] IDX_EXT      = 7'd28;
    localparam logic [INDEX_W-1:0] IDX_VERSION  = 7'd30;

    typedef enum logic [2:0] {
        SEL_DOUT  = 3'd0,
        SEL_DIR   = 3'd1,
        SEL_IEN   = 3'd2,
        SEL_IMASK = 3'd3,
        SEL_ITYPE = 3'd4,
        SEL_IPOL  = 3'd5,
        SEL_IBOTH = 3'd6,
        SEL_NONE  = 3'd7
    } reg_sel_t;

    typedef enum logic [2:0] {
        RD_PAIR,
        RD_STATUS,
        RD_RAW,
        RD_EXT,
        RD_VERSION,
        RD_ZERO
    } read_sel_t;

    typedef struct packed {
        logic      fire;
        logic      wr;
        logic      tick;
        logic      eoi;
        logic      upper;
        reg_sel_t  sel;
        read_sel_t rsel;
    } ctrl_t;

    typedef struct packed {
        logic dout;
        logic dir;
        logic ien;
        logic imask;
        logic itype;
        logic ipol;
        logic iboth;
        logic raw;
        logic last;
    } lane_cur_t;

    typedef struct packed {
        logic dout;
        logic dir;
        logic stat;
    } lane_nxt_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [WORD_W-1:0] drive_levels;
        logic [WORD_W-1:0] drive_enables;
        logic              interrupt_request;
    } out_item_t;

    function automatic ctrl_t decode_req(
        input logic [ACTION_W-1:0] action,
        input logic [INDEX_W-1:0]  reg_index,
        input logic                fire
    );
        ctrl_t c;
        logic  is_pair;
        is_pair = (reg_index < IDX_PAIR_END);
        c.fire  = fire;
        c.wr    = (action == ACT_WRITE);
        c.tick  = (action == ACT_TICK);
        c.eoi   = c.wr && (reg_index == IDX_EOI_L || reg_index == IDX_EOI_H);
        c.upper = reg_index[0];
        c.sel   = is_pair ? reg_sel_t'(reg_index[3:1]) : SEL_NONE;
        c.rsel  = RD_ZERO;
        if (action == ACT_READ)
        begin
            if (is_pair)
            begin
                c.rsel = RD_PAIR;
            end
            else
            begin
                case (reg_index)
                    IDX_STATUS:  c.rsel = RD_STATUS;
                    IDX_RAW:     c.rsel = RD_RAW;
                    IDX_EXT:     c.rsel = RD_EXT;
                    IDX_VERSION: c.rsel = RD_VERSION;
                    default:     c.rsel = RD_ZERO;
                endcase
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/gpioirq_ifs.sv @@
// ----------------------------------------------------------------------------
// GPIO port channel interfaces
// Request, result and version configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface gpioirq_req_if
    import gpioirq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  reg_index;
    logic [WORD_W-1:0]   write_data;
    logic [WORD_W-1:0]   pin_levels;

    modport source (output valid, output action, output reg_index,
                    output write_data, output pin_levels, input ready);
    modport sink   (input valid, input action, input reg_index,
                    input write_data, input pin_levels, output ready);
endinterface

interface gpioirq_rsp_if
    import gpioirq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] drive_levels;
    logic [WORD_W-1:0] drive_enables;
    logic              interrupt_request;

    modport source (output valid, output read_data, output drive_levels,
                    output drive_enables, output interrupt_request, input ready);
    modport sink   (input valid, input read_data, input drive_levels,
                    input drive_enables, input interrupt_request, output ready);
endinterface

interface gpioirq_cfg_if
    import gpioirq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] version_id;

    modport source (output valid, output version_id, input ready);
    modport sink   (input valid, input version_id, output ready);
endinterface

@@ rtl/core/gpioirq_lane.sv @@
// ----------------------------------------------------------------------------
// GPIO pin lane
// Holds the register bits and interrupt detection state of one pin.
// ----------------------------------------------------------------------------
module gpioirq_lane
    import gpioirq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_t     ctrl,
    input  logic      upper,
    input  logic      we_bit,
    input  logic      dat_bit,
    input  logic      pin_bit,
    output lane_cur_t cur,
    output lane_nxt_t nxt
);

    lane_cur_t st_reg;
    lane_cur_t st_next;
    logic      wr_hit;
    logic      edge_pin;
    logic      rise;
    logic      fall;
    logic      hit;

    assign wr_hit   = ctrl.fire && ctrl.wr && (ctrl.upper == upper) && we_bit;
    assign edge_pin = st_reg.itype | st_reg.iboth;
    assign rise     = pin_bit & ~st_reg.last;
    assign fall     = ~pin_bit & st_reg.last;
    assign hit      = st_reg.iboth ? (rise | fall) : (st_reg.ipol ? rise : fall);

    always_comb
    begin
        st_next = st_reg;
        if (wr_hit)
        begin
            case (ctrl.sel)
                SEL_DOUT:  st_next.dout  = dat_bit;
                SEL_DIR:   st_next.dir   = dat_bit;
                SEL_IEN:   st_next.ien   = dat_bit;
                SEL_IMASK: st_next.imask = dat_bit;
                SEL_ITYPE: st_next.itype = dat_bit;
                SEL_IPOL:  st_next.ipol  = dat_bit;
                SEL_IBOTH: st_next.iboth = dat_bit;
                default:   ;
            endcase
            if (ctrl.eoi && dat_bit && edge_pin)
            begin
                st_next.raw = 1'b0;
            end
        end
        if (ctrl.fire && ctrl.tick)
        begin
            st_next.raw  = edge_pin ? (st_reg.raw | hit) : ~(pin_bit ^ st_reg.ipol);
            st_next.last = pin_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign cur      = st_reg;
    assign nxt.dout = st_next.dout;
    assign nxt.dir  = st_next.dir;
    assign nxt.stat = st_next.raw & st_next.ien & ~st_next.imask;

    // A level pin follows the pin against its polarity on every tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && ctrl.tick && !edge_pin) |=>
            (st_reg.raw == $past(~(pin_bit ^ st_reg.ipol))))
        else $error("level pin status does not follow the sampled pin");

endmodule

@@ rtl/core/gpioirq_merge.sv @@
// ----------------------------------------------------------------------------
// GPIO lane merge
// Gathers the pin lanes into words, selects read data, ORs the interrupt.
// ----------------------------------------------------------------------------
module gpioirq_merge
    import gpioirq_pkg::*;
(
    input  ctrl_t             ctrl,
    input  lane_cur_t         cur [PIN_COUNT],
    input  lane_nxt_t         nxt [PIN_COUNT],
    input  logic [WORD_W-1:0] version_id,
    output out_item_t         item
);

    logic [WORD_W-1:0] dout_w;
    logic [WORD_W-1:0] dir_w;
    logic [WORD_W-1:0] ien_w;
    logic [WORD_W-1:0] imask_w;
    logic [WORD_W-1:0] itype_w;
    logic [WORD_W-1:0] ipol_w;
    logic [WORD_W-1:0] iboth_w;
    logic [WORD_W-1:0] raw_w;
    logic [WORD_W-1:0] last_w;
    logic [WORD_W-1:0] dout_n_w;
    logic [WORD_W-1:0] dir_n_w;
    logic [WORD_W-1:0] stat_n_w;
    logic [WORD_W-1:0] pair_w;
    logic [HALF_W-1:0] half_w;

    always_comb
    begin
        dout_w   = '0;
        dir_w    = '0;
        ien_w    = '0;
        imask_w  = '0;
        itype_w  = '0;
        ipol_w   = '0;
        iboth_w  = '0;
        raw_w    = '0;
        last_w   = '0;
        dout_n_w = '0;
        dir_n_w  = '0;
        stat_n_w = '0;
        for (int p = 0; p < PIN_COUNT; p++)
        begin
            dout_w[p]   = cur[p].dout;
            dir_w[p]    = cur[p].dir;
            ien_w[p]    = cur[p].ien;
            imask_w[p]  = cur[p].imask;
            itype_w[p]  = cur[p].itype;
            ipol_w[p]   = cur[p].ipol;
            iboth_w[p]  = cur[p].iboth;
            raw_w[p]    = cur[p].raw;
            last_w[p]   = cur[p].last;
            dout_n_w[p] = nxt[p].dout;
            dir_n_w[p]  = nxt[p].dir;
            stat_n_w[p] = nxt[p].stat;
        end
    end

    always_comb
    begin
        case (ctrl.sel)
            SEL_DOUT:  pair_w = dout_w;
            SEL_DIR:   pair_w = dir_w;
            SEL_IEN:   pair_w = ien_w;
            SEL_IMASK: pair_w = imask_w;
            SEL_ITYPE: pair_w = itype_w;
            SEL_IPOL:  pair_w = ipol_w;
            SEL_IBOTH: pair_w = iboth_w;
            default:   pair_w = '0;
        endcase
        half_w = ctrl.upper ? pair_w[WORD_W-1:HALF_W] : pair_w[HALF_W-1:0];
    end

    always_comb
    begin
        case (ctrl.rsel)
            RD_PAIR:    item.read_data = {{(WORD_W-HALF_W){1'b0}}, half_w};
            RD_STATUS:  item.read_data = raw_w & ien_w & ~imask_w;
            RD_RAW:     item.read_data = raw_w;
            RD_EXT:     item.read_data = last_w;
            RD_VERSION: item.read_data = version_id;
            default:    item.read_data = '0;
        endcase
        item.drive_levels      = dout_n_w;
        item.drive_enables     = dir_n_w;
        item.interrupt_request = |stat_n_w;
    end

endmodule

@@ rtl/core/gpioirq_skid.sv @@
// ----------------------------------------------------------------------------
// GPIO result buffer
// Output register with one skid entry that takes one more result while the receiver stalls.
// ----------------------------------------------------------------------------
module gpioirq_skid
    import gpioirq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  out_item_t push_item,
    output logic      push_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t skid_item_reg;
    out_item_t skid_item_next;
    logic      push;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_item_next   = skid_valid_reg ? skid_item_reg : push_item;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The skid entry is only ever filled behind a held output.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("request taken during a stall was not kept");

    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry did not move to the output");

endmodule

@@ rtl/core/gpio_port_with_irq_detect_core.sv @@
// ----------------------------------------------------------------------------
// GPIO port with interrupt detection
// Thirty-two pin lanes with half-word write-masked registers and edge/level
// interrupt detection, merged into one result per request.
//
// Usage: each request on req is a register read, a register write or a pin
// sample tick, and gives exactly one result on rsp carrying the read data,
// the drive levels and enables after the request and the interrupt line.
// A request is taken when req.valid and req.ready are both high; its result
// is registered; one request is taken every cycle while rsp.ready is high.
// Every pin has its own lane, so the request cost does not depend on how
// many pins change. When the receiver holds rsp.ready low, one more request
// is taken into a skid entry and req.ready then drops until it drains.
// The version register is written through cfg, which is always ready; write
// it only while no request is in flight. Reset clears all pin registers,
// pending interrupts, the sampled pin levels and the version register.
// ----------------------------------------------------------------------------
module gpio_port_with_irq_detect_core
    import gpioirq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    gpioirq_req_if.sink   req,
    gpioirq_rsp_if.source rsp,
    gpioirq_cfg_if.sink   cfg
);

    logic [WORD_W-1:0] version_reg;
    logic [WORD_W-1:0] version_next;
    ctrl_t             ctrl;
    lane_cur_t         cur [PIN_COUNT];
    lane_nxt_t         nxt [PIN_COUNT];
    out_item_t         merged;
    out_item_t         rsp_item;

    assign cfg.ready    = 1'b1;
    assign version_next = (cfg.valid && cfg.ready) ? cfg.version_id : version_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= '0;
        end
        else
        begin
            version_reg <= version_next;
        end
    end

    assign ctrl = decode_req(req.action, req.reg_index, req.valid && req.ready);

    for (genvar p = 0; p < PIN_COUNT; p++)
    begin : g_lane
        gpioirq_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .upper   (1'(p / HALF_W)),
            .we_bit  (req.write_data[HALF_W + (p % HALF_W)]),
            .dat_bit (req.write_data[p % HALF_W]),
            .pin_bit (req.pin_levels[p]),
            .cur     (cur[p]),
            .nxt     (nxt[p])
        );
    end

    gpioirq_merge u_merge (
        .ctrl       (ctrl),
        .cur        (cur),
        .nxt        (nxt),
        .version_id (version_reg),
        .item       (merged)
    );

    gpioirq_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req.valid),
        .push_item  (merged),
        .push_ready (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_item   (rsp_item)
    );

    assign rsp.read_data         = rsp_item.read_data;
    assign rsp.drive_levels      = rsp_item.drive_levels;
    assign rsp.drive_enables     = rsp_item.drive_enables;
    assign rsp.interrupt_request = rsp_item.interrupt_request;

endmodule
